>>> sv/srgb_pkg.sv
// Shared constants, types and knot-table math for the sRGB transfer converter.
package srgb_pkg;

   localparam int QB = 30;
   localparam longint unsigned QONE = 64'd1 << QB;
   localparam longint unsigned DEC_KNEE = (64'd4045 << QB) / 64'd100000;
   localparam longint unsigned ENC_KNEE = (64'd31308 << QB) / 64'd10000000;

   localparam longint unsigned DEC_MUL = 64'd100;
   localparam longint unsigned DEC_RND = 64'd646;
   localparam longint unsigned DEC_DIV = 64'd1292;
   localparam longint unsigned ENC_MUL = 64'd1292;
   localparam longint unsigned ENC_RND = 64'd50;
   localparam longint unsigned ENC_DIV = 64'd100;

   localparam int LIN_SHIFT = 34;
   localparam int MUL_SHIFT = 61;

   localparam int REG_DIRECTION = 0;

   typedef enum logic {
      DIR_DECODE = 1'b0,
      DIR_ENCODE = 1'b1
   } dir_type;

   function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
      return (a * b) >> QB;
   endfunction

   function automatic longint unsigned pow5q(input longint unsigned z);
      longint unsigned z2;
      z2 = qmul(z, z);
      return qmul(qmul(z2, z2), z);
   endfunction

   function automatic longint unsigned pow12q(input longint unsigned z);
      longint unsigned z2, z4, z8;
      z2 = qmul(z, z);
      z4 = qmul(z2, z2);
      z8 = qmul(z4, z4);
      return qmul(z8, z4);
   endfunction

   function automatic longint unsigned largest_root(input longint unsigned t, input logic twelfth);
      longint unsigned lo, hi, mid, p;
      lo = 64'd0;
      hi = QONE;
      for (int i = 0; i < 32; i++) begin
         if (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            p = twelfth ? pow12q(mid) : pow5q(mid);
            if (p <= t) lo = mid;
            else hi = mid - 64'd1;
         end
      end
      return lo;
   endfunction

   function automatic longint unsigned knot_decode(input longint unsigned x);
      longint unsigned t, z;
      t = (x * 64'd1000 + 64'd55 * QONE) / 64'd1055;
      if (t > QONE) t = QONE;
      z = largest_root(t, 1'b0);
      return qmul(qmul(t, t), qmul(z, z));
   endfunction

   function automatic longint unsigned knot_encode(input longint unsigned x);
      longint unsigned z, z2, u, w;
      z = largest_root(x, 1'b1);
      z2 = qmul(z, z);
      u = qmul(qmul(z2, z2), z);
      w = u * 64'd1055;
      if (w <= 64'd55 * QONE) return 64'd0;
      return (w - 64'd55 * QONE) / 64'd1000;
   endfunction

endpackage

>>> sv/srgb_transfer_convert_top.sv
// sRGB transfer function converter: pipelined RGBA pixel datapath with APB control.
//
// Input transfers (req_*) carry one RGBA pixel; output transfers (rsp_*) carry the
// converted pixel. Red, green and blue go through the sRGB curve, alpha is copied.
// The direction register (APB address 0, bit 0) selects encoded-to-linear (0) or
// linear-to-encoded (1); reads return its value. pready is always high.
// One pixel is accepted every cycle unless the output stalls; the 12 register stages
// (input scaling, segment search, knot lookup, interpolation multiply and divide,
// output scaling) each advance together. When the receiver stalls, the whole pipe
// holds and req_ready drops only while the output register is full and rsp_ready is
// low. Reset empties the pipe and sets direction to 0; no table clearing is needed,
// knots are constants.
module srgb_transfer_convert_top #(
   parameter int FRAC_BITS = 16,
   parameter int SEGMENTS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_in_red,
   input  logic [15:0] req_in_green,
   input  logic [15:0] req_in_blue,
   input  logic [15:0] req_in_alpha,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_out_red,
   output logic [15:0] rsp_out_green,
   output logic [15:0] rsp_out_blue,
   output logic [15:0] rsp_out_alpha,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int NL = 3;
   localparam int NS = 12;
   localparam int GW = $clog2(SEGMENTS + 1);
   localparam int RW = $clog2(SEGMENTS) + 2;
   localparam int PW = 30 + GW;
   localparam int OW = 32 + FRAC_BITS;
   localparam int FOLD_STEPS = 48 / (FRAC_BITS - 1) + 3;

   localparam logic [47:0] ONE48 = 48'((64'd1 << FRAC_BITS) - 64'd1);
   localparam logic [47:0] HALF48 = ONE48 >> 1;

   localparam longint unsigned WD = srgb_pkg::QONE - srgb_pkg::DEC_KNEE;
   localparam longint unsigned WE = srgb_pkg::QONE - srgb_pkg::ENC_KNEE;
   localparam longint unsigned RSD = (64'(SEGMENTS) << srgb_pkg::QB) / WD;
   localparam longint unsigned RSE = (64'(SEGMENTS) << srgb_pkg::QB) / WE;
   localparam longint unsigned R2D = (64'd1 << srgb_pkg::MUL_SHIFT) / WD;
   localparam longint unsigned R2E = (64'd1 << srgb_pkg::MUL_SHIFT) / WE;
   localparam longint unsigned RLD = (64'd1 << srgb_pkg::LIN_SHIFT) / srgb_pkg::DEC_DIV;
   localparam longint unsigned RLE = (64'd1 << srgb_pkg::LIN_SHIFT) / srgb_pkg::ENC_DIV;

   typedef logic [30:0] knot_tab_type [SEGMENTS+1];

   function automatic knot_tab_type build_tab(input logic enc);
      knot_tab_type tab;
      longint unsigned knee, span, x, y;
      knee = enc ? srgb_pkg::ENC_KNEE : srgb_pkg::DEC_KNEE;
      span = srgb_pkg::QONE - knee;
      for (int k = 0; k <= SEGMENTS; k++) begin
         x = knee + (64'(k) * span) / SEGMENTS;
         y = enc ? srgb_pkg::knot_encode(x) : srgb_pkg::knot_decode(x);
         if (y > srgb_pkg::QONE) y = srgb_pkg::QONE;
         tab[k] = y[30:0];
      end
      return tab;
   endfunction

   localparam knot_tab_type DEC_TAB = build_tab(1'b0);
   localparam knot_tab_type ENC_TAB = build_tab(1'b1);

   // code * 2^30 / ONE, rounded, by folding on 2^F = ONE + 1
   function automatic logic [30:0] code_to_q(input logic [15:0] c);
      logic [47:0] r, q;
      r = {2'b00, c, 30'd0} + HALF48;
      q = '0;
      for (int i = 0; i < FOLD_STEPS; i++) begin
         q = q + (r >> FRAC_BITS);
         r = (r >> FRAC_BITS) + (r & ONE48);
      end
      if (r >= ONE48) q = q + 48'd1;
      return q[30:0];
   endfunction

   function automatic logic is_enc(input srgb_pkg::dir_type d);
      return d == srgb_pkg::DIR_ENCODE;
   endfunction

   function automatic logic [29:0] span_of(input srgb_pkg::dir_type d);
      return is_enc(d) ? 30'(WE) : 30'(WD);
   endfunction

   // ---------------- control ----------------
   srgb_pkg::dir_type dir_cfg_ff;
   logic [NS:1] vld_ff;
   logic adv;
   logic cfg_wr;

   assign adv       = !vld_ff[NS] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NS];
   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite
                      && (paddr[2] == 1'(srgb_pkg::REG_DIRECTION));
   assign prdata    = (paddr[2] == 1'(srgb_pkg::REG_DIRECTION))
                      ? {31'd0, dir_cfg_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_cfg_ff <= srgb_pkg::DIR_DECODE;
         vld_ff     <= '0;
      end else begin
         if (cfg_wr) dir_cfg_ff <= srgb_pkg::dir_type'(pwdata[0]);
         if (adv) vld_ff <= {vld_ff[NS-1:1], req_valid};
      end
   end

   // ---------------- datapath registers ----------------
   logic [15:0] comp [NL];
   srgb_pkg::dir_type dir_ff [1:9];
   logic [15:0] alpha_ff [1:NS];
   logic [NL-1:0] lin_ff [2:9];
   logic [NL-1:0] lin_in;

   logic [30:0] v1_ff [NL], v1_in [NL];
   logic [29:0] d2_ff [NL], d2_in [NL];
   logic [30+RW-1:0] gp2_ff [NL], gp2_in [NL];
   logic [33:0] ln_ff [NL][2:4], ln2_in [NL];
   logic [PW-1:0] s3_ff [NL], s3_in [NL];
   logic [PW-1:0] gw3_ff [NL], gw3_in [NL];
   logic [GW-1:0] g3_ff [NL], g3_in [NL];
   logic [61:0] lq3_ff [NL], lq3_in [NL];
   logic [GW-1:0] g4_ff [NL], g4_in [NL];
   logic [30:0] p4_ff [NL], p4_in [NL];
   logic [27:0] qe4_ff [NL], qe4_in [NL];
   logic [38:0] m4_ff [NL], m4_in [NL];
   logic [30:0] df5_ff [NL], df5_in [NL];
   logic [30:0] p5_ff [NL];
   logic [30:0] y0_ff [NL][5:9], y05_in [NL];
   logic [NL-1:0] ng_ff [5:9];
   logic [NL-1:0] ng5_in;
   logic [30:0] ql_ff [NL][5:9], ql5_in [NL];
   logic [60:0] pr_ff [NL][6:9], pr6_in [NL];
   logic [63:0] ph7_ff [NL], ph7_in [NL];
   logic [62:0] pl7_ff [NL], pl7_in [NL];
   logic [30:0] qe_ff [NL][8:9], qe8_in [NL];
   logic [60:0] m9_ff [NL], m9_in [NL];
   logic [30:0] q10_ff [NL], q10_in [NL];
   logic [OW-1:0] o11_ff [NL], o11_in [NL];
   logic [15:0] out_ff [NL], out_in [NL];

   assign comp[0] = req_in_red;
   assign comp[1] = req_in_green;
   assign comp[2] = req_in_blue;

   always_comb begin
      logic [15:0] cc;
      logic [30:0] kn;
      logic [RW-1:0] rs;
      logic [41:0] lnw;
      logic [GW-1:0] g;
      logic [PW-1:0] pw;
      logic [30:0] p, w31;
      logic [30:0] y1;
      logic [38:0] rem39;
      logic [64:0] sum;
      logic [60:0] rem61;
      logic [31:0] q32, y32;
      logic [OW-31:0] t;
      for (int l = 0; l < NL; l++) begin
         // stage 1: clamp and scale to Q30
         cc = (48'(comp[l]) > ONE48) ? ONE48[15:0] : comp[l];
         v1_in[l] = code_to_q(cc);

         // stage 2: knee test, segment estimate, linear numerator
         kn = is_enc(dir_ff[1]) ? 31'(srgb_pkg::ENC_KNEE) : 31'(srgb_pkg::DEC_KNEE);
         rs = is_enc(dir_ff[1]) ? RW'(RSE) : RW'(RSD);
         lin_in[l] = (v1_ff[l] <= kn);
         d2_in[l] = lin_in[l] ? 30'd0 : 30'(v1_ff[l] - kn);
         gp2_in[l] = (30+RW)'(d2_in[l]) * (30+RW)'(rs);
         if (is_enc(dir_ff[1]))
            lnw = 42'(v1_ff[l]) * 42'(srgb_pkg::ENC_MUL) + 42'(srgb_pkg::ENC_RND);
         else
            lnw = 42'(v1_ff[l]) * 42'(srgb_pkg::DEC_MUL) + 42'(srgb_pkg::DEC_RND);
         ln2_in[l] = lnw[33:0];

         // stage 3: segment times span, reciprocal multiply for linear part
         g3_in[l] = gp2_ff[l][30 +: GW];
         s3_in[l] = PW'(d2_ff[l]) * PW'(SEGMENTS);
         gw3_in[l] = PW'(g3_in[l]) * PW'(span_of(dir_ff[2]));
         lq3_in[l] = 62'(ln_ff[l][2]) *
                     (is_enc(dir_ff[2]) ? 62'(RLE) : 62'(RLD));

         // stage 4: correct segment and offset
         w31 = 31'(span_of(dir_ff[3]));
         pw = s3_ff[l] - gw3_ff[l];
         p = pw[30:0];
         g = g3_ff[l];
         if (p >= w31) begin
            p = p - w31;
            g = g + GW'(1);
         end
         if (g == GW'(SEGMENTS)) begin
            g = GW'(SEGMENTS - 1);
            p = p + w31;
         end
         g4_in[l] = g;
         p4_in[l] = p;
         qe4_in[l] = lq3_ff[l][61:34];
         m4_in[l] = 39'(qe4_in[l]) *
                    (is_enc(dir_ff[3]) ? 39'(srgb_pkg::ENC_DIV) : 39'(srgb_pkg::DEC_DIV));

         // stage 5: knot lookup, linear quotient correction
         if (is_enc(dir_ff[4])) begin
            y05_in[l] = ENC_TAB[g4_ff[l]];
            y1 = ENC_TAB[g4_ff[l] + GW'(1)];
         end else begin
            y05_in[l] = DEC_TAB[g4_ff[l]];
            y1 = DEC_TAB[g4_ff[l] + GW'(1)];
         end
         ng5_in[l] = (y1 < y05_in[l]);
         df5_in[l] = ng5_in[l] ? (y05_in[l] - y1) : (y1 - y05_in[l]);
         rem39 = 39'(ln_ff[l][4]) - m4_ff[l];
         ql5_in[l] = 31'(qe4_ff[l]) +
                     ((rem39 >= (is_enc(dir_ff[4]) ? 39'(srgb_pkg::ENC_DIV)
                                                   : 39'(srgb_pkg::DEC_DIV))) ? 31'd1 : 31'd0);

         // stage 6: interpolation product
         pr6_in[l] = 61'(62'(df5_ff[l]) * 62'(p5_ff[l]));

         // stage 7: partial products with reciprocal of span
         ph7_in[l] = 64'(pr_ff[l][6][60:30]) * (is_enc(dir_ff[6]) ? 64'(R2E) : 64'(R2D));
         pl7_in[l] = 63'(pr_ff[l][6][29:0]) * (is_enc(dir_ff[6]) ? 63'(R2E) : 63'(R2D));

         // stage 8: quotient estimate
         sum = 65'(ph7_ff[l]) + 65'(pl7_ff[l] >> 30);
         qe8_in[l] = sum[61:31];

         // stage 9: estimate times span
         m9_in[l] = 61'(qe_ff[l][8]) * 61'(span_of(dir_ff[8]));

         // stage 10: quotient correction and result select
         rem61 = pr_ff[l][9] - m9_ff[l];
         q32 = 32'(qe_ff[l][9]) + ((rem61 >= 61'(span_of(dir_ff[9]))) ? 32'd1 : 32'd0);
         y32 = ng_ff[9][l] ? (32'(y0_ff[l][9]) - q32) : (32'(y0_ff[l][9]) + q32);
         if (lin_ff[9][l]) y32 = 32'(ql_ff[l][9]);
         if (y32 > 32'(srgb_pkg::QONE)) y32 = 32'(srgb_pkg::QONE);
         q10_in[l] = y32[30:0];

         // stage 11: scale back to code
         o11_in[l] = OW'(q10_ff[l]) * OW'(ONE48) + (OW'(1) << (srgb_pkg::QB - 1));

         // stage 12: shift and saturate
         t = o11_ff[l][OW-1:30];
         out_in[l] = (t > (OW-30)'(16'hFFFF)) ? 16'hFFFF : t[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dir_ff[1] <= dir_cfg_ff;
         for (int k = 2; k <= 9; k++) dir_ff[k] <= dir_ff[k-1];
         alpha_ff[1] <= req_in_alpha;
         for (int k = 2; k <= NS; k++) alpha_ff[k] <= alpha_ff[k-1];
         lin_ff[2] <= lin_in;
         for (int k = 3; k <= 9; k++) lin_ff[k] <= lin_ff[k-1];
         ng_ff[5] <= ng5_in;
         for (int k = 6; k <= 9; k++) ng_ff[k] <= ng_ff[k-1];
         for (int l = 0; l < NL; l++) begin
            v1_ff[l]     <= v1_in[l];
            d2_ff[l]     <= d2_in[l];
            gp2_ff[l]    <= gp2_in[l];
            ln_ff[l][2]  <= ln2_in[l];
            ln_ff[l][3]  <= ln_ff[l][2];
            ln_ff[l][4]  <= ln_ff[l][3];
            s3_ff[l]     <= s3_in[l];
            gw3_ff[l]    <= gw3_in[l];
            g3_ff[l]     <= g3_in[l];
            lq3_ff[l]    <= lq3_in[l];
            g4_ff[l]     <= g4_in[l];
            p4_ff[l]     <= p4_in[l];
            qe4_ff[l]    <= qe4_in[l];
            m4_ff[l]     <= m4_in[l];
            df5_ff[l]    <= df5_in[l];
            p5_ff[l]     <= p4_ff[l];
            y0_ff[l][5]  <= y05_in[l];
            ql_ff[l][5]  <= ql5_in[l];
            for (int k = 6; k <= 9; k++) begin
               y0_ff[l][k] <= y0_ff[l][k-1];
               ql_ff[l][k] <= ql_ff[l][k-1];
            end
            pr_ff[l][6]  <= pr6_in[l];
            for (int k = 7; k <= 9; k++) pr_ff[l][k] <= pr_ff[l][k-1];
            ph7_ff[l]    <= ph7_in[l];
            pl7_ff[l]    <= pl7_in[l];
            qe_ff[l][8]  <= qe8_in[l];
            qe_ff[l][9]  <= qe_ff[l][8];
            m9_ff[l]     <= m9_in[l];
            q10_ff[l]    <= q10_in[l];
            o11_ff[l]    <= o11_in[l];
            out_ff[l]    <= out_in[l];
         end
      end
   end

   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];
   assign rsp_out_alpha = alpha_ff[NS];

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipe moved during stall");

   a_segment_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> ((lin_ff[4][0] || g4_ff[0] <= GW'(SEGMENTS - 1))
                  && (lin_ff[4][1] || g4_ff[1] <= GW'(SEGMENTS - 1))
                  && (lin_ff[4][2] || g4_ff[2] <= GW'(SEGMENTS - 1))))
      else $error("segment index out of range");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS-1] && adv |=> rsp_valid)
      else $error("transfer lost before output");

endmodule
